// ===== design/direct_mapped_writeback_cache_assert.svh =====
// Assertion macros for the direct-mapped write-back cache.
// Included by the controller and datapath modules; depends on nothing else.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DMWBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DMWBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`define DMWBC_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DMWBC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DMWBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define DMWBC_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== design/dmwbc_pkg.sv =====
// Shared types and constants for the direct-mapped write-back cache.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package dmwbc_pkg;
  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int CACHE_BYTES_DEF = 256;
  localparam int LINE_BYTES_DEF = 8;
  localparam int MEMORY_BYTES_DEF = 65536;

  localparam logic MODE_READ = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WRITEBACK,
    ST_FILL,
    ST_ACCESS,
    ST_RESPOND
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic check;
    logic cnt_reset;
    logic wb_step;
    logic fill_step;
    logic fill_commit;
    logic acc_write;
    logic acc_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_last;
    logic hit;
    logic victim_dirty;
    logic is_write;
  } ctrl_status_t;
endpackage
`default_nettype wire

// ===== design/dmwbc_datapath.sv =====
// Datapath of the cache: backing memory, line store, tags, flags and counters.
// Depends on dmwbc_pkg and the assertion macro header.
`default_nettype none
`include "direct_mapped_writeback_cache_assert.svh"
module dmwbc_datapath #(
  parameter int CACHE_BYTES = dmwbc_pkg::CACHE_BYTES_DEF,
  parameter int LINE_BYTES = dmwbc_pkg::LINE_BYTES_DEF,
  parameter int MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [dmwbc_pkg::ADDR_W-1:0] address,
  input  wire logic                        mode,
  input  wire logic [dmwbc_pkg::DATA_W-1:0] write_data,
  input  wire dmwbc_pkg::ctrl_cmd_t        cmd,
  output dmwbc_pkg::ctrl_status_t          status,
  output logic [dmwbc_pkg::DATA_W-1:0]     read_data,
  output logic                             hit,
  output logic                             line_was_dirty
);
  localparam int NUM_LINES = (CACHE_BYTES / LINE_BYTES > 0) ? CACHE_BYTES / LINE_BYTES : 1;
  localparam int STORE_BYTES = NUM_LINES * LINE_BYTES;
  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int CACHE_BITS = $clog2(CACHE_BYTES);
  localparam int OFF_W = (OFF_BITS > 0) ? OFF_BITS : 1;
  localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int TAG_W = (dmwbc_pkg::ADDR_W - CACHE_BITS > 0) ?
                         dmwbc_pkg::ADDR_W - CACHE_BITS : 1;
  localparam int SLOT_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int MEM_W = $clog2(MEMORY_BYTES);
  localparam int CNT_W = $clog2(LINE_BYTES + 1);

  logic [dmwbc_pkg::DATA_W-1:0] backing_mem [MEMORY_BYTES];
  logic [dmwbc_pkg::DATA_W-1:0] line_store [STORE_BYTES];
  logic [TAG_W-1:0]             tag_mem [NUM_LINES];

  logic [NUM_LINES-1:0] valid;
  logic [NUM_LINES-1:0] dirty;
  logic [TAG_W-1:0]     tag_q;
  logic [IDX_W-1:0]     idx_r;
  logic [TAG_W-1:0]     tag_r;
  logic [OFF_W-1:0]     off_r;
  logic                 mode_r;
  logic [dmwbc_pkg::DATA_W-1:0] wdata_r;
  logic                 hit_r;
  logic                 dirty_r;
  logic [CNT_W-1:0]     cnt;
  logic [MEM_W-1:0]     clr_cnt;
  logic [dmwbc_pkg::DATA_W-1:0] mem_q;
  logic [dmwbc_pkg::DATA_W-1:0] store_q;

  logic [31:0] addr32;
  logic [31:0] idx_full;
  logic [31:0] tag_full;
  logic [31:0] off_full;
  logic [IDX_W-1:0] idx_in;
  logic [TAG_W-1:0] tag_in;
  logic [OFF_W-1:0] off_in;
  logic [CNT_W-1:0] cnt_m1;
  logic [31:0] slot_base;
  logic [31:0] slot_cnt;
  logic [31:0] slot_cnt_m1;
  logic [31:0] slot_off;
  logic [31:0] victim_addr;
  logic [31:0] fill_addr;
  logic        cnt_in_line;
  logic        cnt_nonzero;

  logic                         mem_we;
  logic [MEM_W-1:0]             mem_waddr;
  logic [dmwbc_pkg::DATA_W-1:0] mem_wdata;
  logic [MEM_W-1:0]             mem_raddr;
  logic                         store_we;
  logic [SLOT_W-1:0]            store_waddr;
  logic [dmwbc_pkg::DATA_W-1:0] store_wdata;
  logic [SLOT_W-1:0]            store_raddr;

  always_comb begin
    addr32 = {{(32 - dmwbc_pkg::ADDR_W){1'b0}}, address};
    idx_full = (addr32 >> OFF_BITS) & 32'(NUM_LINES - 1);
    tag_full = addr32 >> CACHE_BITS;
    off_full = addr32 & 32'(LINE_BYTES - 1);
    idx_in = idx_full[IDX_W-1:0];
    tag_in = tag_full[TAG_W-1:0];
    off_in = off_full[OFF_W-1:0];

    cnt_m1 = cnt - CNT_W'(1);
    cnt_in_line = (32'(cnt) < 32'(LINE_BYTES));
    cnt_nonzero = (cnt != '0);
    slot_base = 32'(idx_r) << OFF_BITS;
    slot_cnt = slot_base + 32'(cnt);
    slot_cnt_m1 = slot_base + 32'(cnt_m1);
    slot_off = slot_base + 32'(off_r);
    victim_addr = (32'(tag_q) << CACHE_BITS) + slot_base + 32'(cnt_m1);
    fill_addr = (32'(tag_r) << CACHE_BITS) + slot_base + 32'(cnt);

    mem_we = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = '0;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.wb_step && cnt_nonzero) begin
      mem_we = 1'b1;
      mem_waddr = victim_addr[MEM_W-1:0];
      mem_wdata = store_q;
    end
    mem_raddr = fill_addr[MEM_W-1:0];

    store_we = 1'b0;
    store_waddr = slot_cnt_m1[SLOT_W-1:0];
    store_wdata = mem_q;
    if (cmd.fill_step && cnt_nonzero) begin
      store_we = 1'b1;
    end else if (cmd.acc_write) begin
      store_we = 1'b1;
      store_waddr = slot_off[SLOT_W-1:0];
      store_wdata = wdata_r;
    end
    store_raddr = cmd.acc_read ? slot_off[SLOT_W-1:0] : slot_cnt[SLOT_W-1:0];

    status.clr_last = (clr_cnt == MEM_W'(MEMORY_BYTES - 1));
    status.cnt_last = (32'(cnt) == 32'(LINE_BYTES));
    status.hit = valid[idx_r] && (tag_q == tag_r);
    status.victim_dirty = valid[idx_r] && dirty[idx_r];
    status.is_write = (mode_r == dmwbc_pkg::MODE_WRITE);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      backing_mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= backing_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      line_store[store_waddr] <= store_wdata;
    end
    if (cnt_in_line || cmd.acc_read) begin
      store_q <= line_store[store_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_commit) begin
      tag_mem[idx_r] <= tag_r;
    end
    if (cmd.accept) begin
      tag_q <= tag_mem[idx_in];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= idx_in;
      tag_r <= tag_in;
      off_r <= off_in;
      mode_r <= mode;
      wdata_r <= write_data;
    end
    if (cmd.check) begin
      hit_r <= status.hit;
      dirty_r <= dirty[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
      cnt <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + MEM_W'(1);
      end
      if (cmd.cnt_reset) begin
        cnt <= '0;
      end else if (cmd.wb_step || cmd.fill_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.fill_commit) begin
        valid[idx_r] <= 1'b1;
        dirty[idx_r] <= 1'b0;
      end
      if (cmd.acc_write) begin
        dirty[idx_r] <= 1'b1;
      end
    end
  end

  assign read_data = store_q;
  assign hit = hit_r;
  assign line_was_dirty = dirty_r;

  `DMWBC_ASSERT_NEXT(a_fill_marks_clean, clk, rst, cmd.fill_commit, valid[idx_r] && !dirty[idx_r], "refilled line not valid and clean")
  `DMWBC_ASSERT_NEXT(a_write_marks_dirty, clk, rst, cmd.acc_write, dirty[idx_r], "written line not dirty")
  `DMWBC_ASSERT_NEVER(a_cnt_range, clk, rst, 32'(cnt) > 32'(LINE_BYTES), "byte counter past line end")
endmodule
`default_nettype wire

// ===== design/dmwbc_ctrl.sv =====
// Controller state machine of the cache: clearing pass, lookup, write-back, refill.
// Depends on dmwbc_pkg and the assertion macro header.
`default_nettype none
`include "direct_mapped_writeback_cache_assert.svh"
module dmwbc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  output logic                        done,
  output dmwbc_pkg::ctrl_cmd_t        cmd,
  input  wire dmwbc_pkg::ctrl_status_t status
);
  dmwbc_pkg::state_t state;
  dmwbc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmwbc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != dmwbc_pkg::ST_IDLE);
    done = 1'b0;
    unique case (state)
      dmwbc_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = dmwbc_pkg::ST_IDLE;
        end
      end
      dmwbc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = dmwbc_pkg::ST_LOOKUP;
        end
      end
      dmwbc_pkg::ST_LOOKUP: begin
        cmd.check = 1'b1;
        cmd.cnt_reset = 1'b1;
        priority if (status.hit) begin
          state_next = dmwbc_pkg::ST_ACCESS;
        end else if (status.victim_dirty) begin
          state_next = dmwbc_pkg::ST_WRITEBACK;
        end else begin
          state_next = dmwbc_pkg::ST_FILL;
        end
      end
      dmwbc_pkg::ST_WRITEBACK: begin
        cmd.wb_step = 1'b1;
        if (status.cnt_last) begin
          cmd.cnt_reset = 1'b1;
          state_next = dmwbc_pkg::ST_FILL;
        end
      end
      dmwbc_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.cnt_last) begin
          cmd.cnt_reset = 1'b1;
          cmd.fill_commit = 1'b1;
          state_next = dmwbc_pkg::ST_ACCESS;
        end
      end
      dmwbc_pkg::ST_ACCESS: begin
        if (status.is_write) begin
          cmd.acc_write = 1'b1;
          state_next = dmwbc_pkg::ST_IDLE;
        end else begin
          cmd.acc_read = 1'b1;
          state_next = dmwbc_pkg::ST_RESPOND;
        end
      end
      dmwbc_pkg::ST_RESPOND: begin
        done = 1'b1;
        state_next = dmwbc_pkg::ST_IDLE;
      end
      default: begin
        state_next = dmwbc_pkg::ST_IDLE;
      end
    endcase
  end

  `DMWBC_ASSERT_NEXT(a_accept_to_lookup, clk, rst, start && !busy, state == dmwbc_pkg::ST_LOOKUP, "accepted transaction did not start lookup")
  `DMWBC_ASSERT_IMPL(a_respond_after_read, clk, rst, done, $past(cmd.acc_read), "result without a preceding read access")
  `DMWBC_ASSERT_IMPL(a_done_while_busy, clk, rst, done, busy, "result strobe while idle")
endmodule
`default_nettype wire

// ===== design/direct_mapped_writeback_cache.sv =====
// Direct-mapped write-back cache over an internal byte memory; a read gives one result.
// After reset a clearing pass zeroes all MEMORY_BYTES bytes (65536 by default) of memory
// with busy high. A write hit returns to idle after its access; a read ends with done.
// A miss adds a byte-by-byte refill of the line, and a dirty victim a write-back of the
// old line before it, since the single memory ports move one byte a cycle. The receiver cannot
// stall; done marks each read result for one cycle. Depends on dmwbc_pkg and submodules.
`default_nettype none
module direct_mapped_writeback_cache #(
  parameter int CACHE_BYTES = dmwbc_pkg::CACHE_BYTES_DEF,
  parameter int LINE_BYTES = dmwbc_pkg::LINE_BYTES_DEF,
  parameter int MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [dmwbc_pkg::ADDR_W-1:0] address,
  input  wire logic                        mode,
  input  wire logic [dmwbc_pkg::DATA_W-1:0] write_data,
  output logic                             done,
  output logic [dmwbc_pkg::DATA_W-1:0]     read_data,
  output logic                             hit,
  output logic                             line_was_dirty
);
  dmwbc_pkg::ctrl_cmd_t    cmd;
  dmwbc_pkg::ctrl_status_t status;

  dmwbc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  dmwbc_datapath #(
    .CACHE_BYTES  (CACHE_BYTES),
    .LINE_BYTES   (LINE_BYTES),
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .address        (address),
    .mode           (mode),
    .write_data     (write_data),
    .cmd            (cmd),
    .status         (status),
    .read_data      (read_data),
    .hit            (hit),
    .line_was_dirty (line_was_dirty)
  );
endmodule
`default_nettype wire
